[rtl/core/cct_pkg.sv]
// Package with shared types and constants of the conflict count table.
`timescale 1ns / 1ps
package cct_pkg;
    localparam int unsigned CoordW = 10;
    localparam int unsigned TimeW  = 16;
    localparam int unsigned CntW   = 16;
    localparam int unsigned SumW   = 18;
    localparam logic [CntW-1:0] CntMax = 16'hFFFF;

    typedef enum logic [2:0] {
        FN_ADD_VERTEX = 3'd0,
        FN_ADD_EDGE   = 3'd1,
        FN_ADD_GOAL   = 3'd2,
        FN_REM_VERTEX = 3'd3,
        FN_REM_EDGE   = 3'd4,
        FN_QUERY      = 3'd5,
        FN_CLEAR      = 3'd6,
        FN_NOP        = 3'd7
    } t_func;

    typedef struct packed {
        logic [2:0]        func;
        logic [CoordW-1:0] from_x;
        logic [CoordW-1:0] from_y;
        logic [CoordW-1:0] to_x;
        logic [CoordW-1:0] to_y;
        logic [TimeW-1:0]  time_step;
    } t_req;

    typedef struct packed {
        logic [SumW-1:0] conflict_count;
        logic            status;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } t_state;

    // Store selection for the scan sequencer.
    typedef enum logic [1:0] {
        TB_VERTEX,
        TB_EDGE,
        TB_GOAL
    } t_tbl;
endpackage

[rtl/core/cct_if.sv]
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface cct_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/conflict_count_table.sv]
// Top level of the conflict count table: sequenced scan over three stores.
// A query scans the vertex, edge and goal stores in turn, an add or remove scans one
// store, a clear runs a clearing pass and the unused code goes straight to done.
// A new transaction is accepted only in idle, after the last one has finished.
// A result waiting in the output register stalls only the end of the next one.
// Reset (synchronous, active low) runs a clearing pass over all entries of every store.
`timescale 1ns / 1ps
module conflict_count_table
    import cct_pkg::*;
#(
    parameter int unsigned VERTEX_ENTRIES = 256,
    parameter int unsigned EDGE_ENTRIES   = 256,
    parameter int unsigned GOAL_ENTRIES   = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cct_if.sink   in_ch,
    cct_if.source out_ch
);
    localparam int unsigned VAW = $clog2(VERTEX_ENTRIES);
    localparam int unsigned EAW = $clog2(EDGE_ENTRIES);
    localparam int unsigned GAW = $clog2(GOAL_ENTRIES);
    localparam int unsigned MAXD = (VERTEX_ENTRIES > EDGE_ENTRIES) ?
        ((VERTEX_ENTRIES > GOAL_ENTRIES) ? VERTEX_ENTRIES : GOAL_ENTRIES) :
        ((EDGE_ENTRIES > GOAL_ENTRIES) ? EDGE_ENTRIES : GOAL_ENTRIES);
    localparam int unsigned IW = $clog2(MAXD + 1);
    localparam int unsigned VKW = 2*CoordW + TimeW;
    localparam int unsigned EKW = 4*CoordW + TimeW;
    localparam int unsigned GKW = 2*CoordW;

    // Memories: key plus count per entry (goal entries also hold a start time); count zero means empty.
    logic [VKW+CntW-1:0]     vmem [VERTEX_ENTRIES];
    logic [EKW+CntW-1:0]     emem [EDGE_ENTRIES];
    logic [GKW+TimeW+CntW-1:0] gmem [GOAL_ENTRIES];

    t_state r_state, n_state;
    t_tbl   r_tbl, n_tbl;
    t_req   r_req;
    logic [IW-1:0] r_idx, n_idx;
    logic   r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [VKW+CntW-1:0] r_vrd;
    logic [EKW+CntW-1:0] r_erd;
    logic [GKW+TimeW+CntW-1:0] r_grd;
    logic   r_hit, r_free_vld;
    logic [IW-1:0] r_hit_idx, r_free_idx;
    logic [CntW-1:0] r_hit_cnt;
    logic [TimeW-1:0] r_hit_start;
    logic [SumW-1:0] r_sum;
    logic   r_status;
    logic   r_out_vld;
    logic   r_boot;
    t_rsp   r_rsp;

    logic [VKW-1:0] vkey;
    logic [EKW-1:0] ekey;
    logic [GKW-1:0] gkey;
    logic [IW-1:0]  depth;
    logic           scan_last;
    logic           is_query;
    logic           done_fire;

    assign vkey = {r_req.to_x, r_req.to_y, r_req.time_step};
    assign ekey = {r_req.from_x, r_req.from_y, r_req.to_x, r_req.to_y, r_req.time_step};
    assign gkey = {r_req.to_x, r_req.to_y};
    assign is_query = (t_func'(r_req.func) == FN_QUERY);

    always_comb begin
        unique case (r_tbl)
            TB_VERTEX: depth = IW'(VERTEX_ENTRIES);
            TB_EDGE:   depth = IW'(EDGE_ENTRIES);
            TB_GOAL:   depth = IW'(GOAL_ENTRIES);
            default:   depth = IW'(GOAL_ENTRIES);
        endcase
    end
    assign scan_last = (r_idx == depth);

    // Handshake: the output register holds a result while the next transaction runs.
    assign done_fire    = (r_state == ST_DONE) && (!r_out_vld || out_ch.ready);
    assign in_ch.ready  = (r_state == ST_IDLE);
    assign out_ch.valid = r_out_vld;
    assign out_ch.data  = r_rsp;

    // Compare of the registered read entry against the key (the shared unit).
    logic cur_empty, cur_match;
    logic [CntW-1:0] cur_cnt;
    logic [TimeW-1:0] cur_start;
    always_comb begin
        cur_cnt = '0;
        cur_start = '0;
        cur_match = 1'b0;
        unique case (r_tbl)
            TB_VERTEX: begin
                cur_cnt = r_vrd[CntW-1:0];
                cur_match = (r_vrd[VKW+CntW-1:CntW] == vkey);
            end
            TB_EDGE: begin
                cur_cnt = r_erd[CntW-1:0];
                cur_match = (r_erd[EKW+CntW-1:CntW] == ekey);
            end
            TB_GOAL: begin
                cur_cnt = r_grd[CntW-1:0];
                cur_start = r_grd[TimeW+CntW-1:CntW];
                cur_match = (r_grd[GKW+TimeW+CntW-1:TimeW+CntW] == gkey);
            end
            default: ;
        endcase
        cur_empty = (cur_cnt == '0);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_tbl   = r_tbl;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (in_ch.valid && in_ch.ready) begin
                    n_idx = '0;
                    unique case (t_func'(in_ch.data.func))
                        FN_ADD_VERTEX, FN_REM_VERTEX, FN_QUERY: begin
                            n_state = ST_SCAN; n_tbl = TB_VERTEX;
                        end
                        FN_ADD_EDGE, FN_REM_EDGE: begin
                            n_state = ST_SCAN; n_tbl = TB_EDGE;
                        end
                        FN_ADD_GOAL: begin
                            n_state = ST_SCAN; n_tbl = TB_GOAL;
                        end
                        FN_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == IW'(MAXD - 1)) n_state = r_boot ? ST_IDLE : ST_DONE;
            end
            ST_SCAN: begin
                if (r_hit && r_rd_vld == 1'b0 && scan_last) begin
                    n_state = ST_UPDATE;
                end else if (scan_last && !r_rd_vld) begin
                    n_state = ST_UPDATE;
                end else if (!scan_last) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_UPDATE: begin
                n_idx = '0;
                if (is_query && r_tbl == TB_VERTEX) begin
                    n_state = ST_SCAN; n_tbl = TB_EDGE;
                end else if (is_query && r_tbl == TB_EDGE) begin
                    n_state = ST_SCAN; n_tbl = TB_GOAL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (done_fire) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_tbl   <= TB_VERTEX;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_tbl   <= n_tbl;
            r_idx   <= n_idx;
        end
    end

    // The clearing pass after reset produces no result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_boot <= 1'b1;
        else if (r_state == ST_CLEAR && r_idx == IW'(MAXD - 1)) r_boot <= 1'b0;
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) r_req <= in_ch.data;
    end

    // Registered memory reads, one entry per cycle of the scan.
    always_ff @(posedge i_clk) begin
        r_vrd    <= vmem[r_idx[VAW-1:0]];
        r_erd    <= emem[r_idx[EAW-1:0]];
        r_grd    <= gmem[r_idx[GAW-1:0]];
        r_rd_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_vld <= 1'b0;
        else r_rd_vld <= (r_state == ST_SCAN) && !scan_last;
    end

    // Match and first-free tracking over the scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || r_state == ST_IDLE || r_state == ST_UPDATE) begin
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
        end else if (r_state == ST_SCAN && r_rd_vld) begin
            if (cur_empty) begin
                if (!r_free_vld) begin
                    r_free_vld <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
            end else if (cur_match && !r_hit) begin
                r_hit       <= 1'b1;
                r_hit_idx   <= r_rd_idx;
                r_hit_cnt   <= cur_cnt;
                r_hit_start <= cur_start;
            end
        end
    end

    // Update: one read-modify-write and the sum for a query.
    logic [CntW-1:0] inc_cnt;
    assign inc_cnt = (r_hit_cnt == CntMax) ? r_hit_cnt : r_hit_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            if (r_idx < IW'(VERTEX_ENTRIES)) vmem[r_idx[VAW-1:0]] <= '0;
            if (r_idx < IW'(EDGE_ENTRIES))   emem[r_idx[EAW-1:0]] <= '0;
            if (r_idx < IW'(GOAL_ENTRIES))   gmem[r_idx[GAW-1:0]] <= '0;
        end else if (r_state == ST_UPDATE) begin
            unique case (t_func'(r_req.func))
                FN_ADD_VERTEX: begin
                    if (r_hit) vmem[r_hit_idx[VAW-1:0]] <= {vkey, inc_cnt};
                    else if (r_free_vld)
                        vmem[r_free_idx[VAW-1:0]] <= {vkey, CntW'(1)};
                end
                FN_ADD_EDGE: begin
                    if (r_hit) emem[r_hit_idx[EAW-1:0]] <= {ekey, inc_cnt};
                    else if (r_free_vld)
                        emem[r_free_idx[EAW-1:0]] <= {ekey, CntW'(1)};
                end
                FN_ADD_GOAL: begin
                    if (r_hit)
                        gmem[r_hit_idx[GAW-1:0]] <= {gkey, r_req.time_step, inc_cnt};
                    else if (r_free_vld)
                        gmem[r_free_idx[GAW-1:0]] <= {gkey, r_req.time_step, CntW'(1)};
                end
                FN_REM_VERTEX: begin
                    if (r_hit) begin
                        if (r_hit_cnt == CntW'(1)) vmem[r_hit_idx[VAW-1:0]] <= '0;
                        else vmem[r_hit_idx[VAW-1:0]] <= {vkey, r_hit_cnt - 1'b1};
                    end
                end
                FN_REM_EDGE: begin
                    if (r_hit) begin
                        if (r_hit_cnt == CntW'(1)) emem[r_hit_idx[EAW-1:0]] <= '0;
                        else emem[r_hit_idx[EAW-1:0]] <= {ekey, r_hit_cnt - 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_sum    <= '0;
            r_status <= 1'b0;
        end else if (r_state == ST_UPDATE) begin
            if (is_query && r_hit &&
                (r_tbl != TB_GOAL || r_req.time_step >= r_hit_start))
                r_sum <= r_sum + SumW'(r_hit_cnt);
            if (!r_hit && !r_free_vld &&
                (t_func'(r_req.func) == FN_ADD_VERTEX ||
                 t_func'(r_req.func) == FN_ADD_EDGE ||
                 t_func'(r_req.func) == FN_ADD_GOAL))
                r_status <= 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (done_fire) begin
            r_out_vld <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_vld <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_rsp.conflict_count <= r_sum;
            r_rsp.status         <= r_status;
        end
    end

    // Checks on the sequencer.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_ch.ready)
        else $error("input accepted while busy");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> r_out_vld)
        else $error("result not presented after completion");
    a_sum_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !is_query) |-> (r_sum == '0))
        else $error("nonzero count for non-query");
endmodule
